@@ hw/rtl/fcwh_pkg.sv @@
// ----------------------------------------------------------------------------
// fcwh_pkg
// Shared widths, codes and types of the fan curve block.
// ----------------------------------------------------------------------------
package fcwh_pkg;

    localparam int TEMP_W        = 8;
    localparam int SPEED_W       = 7;
    localparam int HYST_W        = 8;
    localparam int POINT_COUNT_W = 5;
    localparam int INDEX_W       = 4;
    localparam int CFG_DATA_W    = 8;
    localparam int CFG_INDEX_W   = 1;
    localparam int NUM_W         = SPEED_W + TEMP_W;
    localparam int MAX_POINTS_DEF = 16;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_HYSTERESIS  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_POINT_COUNT = 1'b1;

    // Request kinds.
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_WRITE  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic [TEMP_W-1:0]  temp;
        logic [SPEED_W-1:0] speed;
    } curve_entry_t;

    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  num;
        logic [TEMP_W-1:0] den;
    } div_request_t;

    typedef struct packed {
        logic              done;
        logic [NUM_W-1:0]  quot;
        logic [TEMP_W-1:0] rem;
    } div_result_t;

endpackage

@@ hw/rtl/fcwh_curve_mem.sv @@
// ----------------------------------------------------------------------------
// fcwh_curve_mem
// Curve point memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fcwh_curve_mem
    import fcwh_pkg::*;
#(
    parameter int DEPTH = MAX_POINTS_DEF,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic         clk,
    input  logic         wr_en,
    input  logic [AW-1:0] wr_addr,
    input  curve_entry_t wr_data,
    input  logic         rd_en,
    input  logic [AW-1:0] rd_addr,
    output curve_entry_t rd_data
);

    curve_entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hw/rtl/fcwh_div.sv @@
// ----------------------------------------------------------------------------
// fcwh_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fcwh_div
    import fcwh_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  div_request_t req,
    output div_result_t  res
);

    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_W - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [TEMP_W-1:0] rem_reg;
    logic [TEMP_W-1:0] den_reg;

    logic [TEMP_W:0]   trial;
    logic              fits;
    logic [TEMP_W:0]   diff;

    always_comb
    begin
        trial = {rem_reg, quo_reg[NUM_W-1]};
        fits  = trial >= {1'b0, den_reg};
        diff  = trial - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            // The done pulse is registered at the same edge that shifts in the last quotient bit.
            done_reg <= busy_reg && (cnt_reg == LAST_STEP);
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            quo_reg <= req.num;
            rem_reg <= '0;
            den_reg <= req.den;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? diff[TEMP_W-1:0] : trial[TEMP_W-1:0];
        end
    end

    assign res.done = done_reg;
    assign res.quot = quo_reg;
    assign res.rem  = rem_reg;

endmodule

@@ hw/rtl/fan_curve_with_hysteresis.sv @@
// ----------------------------------------------------------------------------
// fan_curve_with_hysteresis
// Maps temperature samples through a piecewise linear fan curve, with a
// hysteresis band on falling temperatures.
// ----------------------------------------------------------------------------
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-----------------------------------
//   input    | in_valid / in_stall        | req_type, temperature,
//            |                            | point_index, point_speed
//   output   | out_valid / out_stall      | fan_speed
//   config   | cfg_wr_en                  | cfg_index, cfg_wdata
//
// A curve point write, and a sample that gives no speed, are done in the
// idle state without leaving it. A sample that gives a speed scans the n
// points in use from the curve memory, one per cycle, and then takes the
// speed of a hit point or of an end of the curve, or interpolates through
// the iterative divider. Reset clears the control state, the
// previous and reference temperatures and both registers; the curve memory
// holds nothing until it is written. in_stall is high while a sample is in
// flight; a finished speed waits in the output register, so a new request is
// taken while out_stall holds the previous one.
// ----------------------------------------------------------------------------
module fan_curve_with_hysteresis
    import fcwh_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,

    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   req_type,
    input  logic [TEMP_W-1:0]      temperature,
    input  logic [INDEX_W-1:0]     point_index,
    input  logic [SPEED_W-1:0]     point_speed,

    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [SPEED_W-1:0]     fan_speed
);

    // Address width of the curve memory, and a count width that holds both
    // the saturated point count and any slot index.
    localparam int AW = $clog2(MAX_POINTS);
    localparam int SW = $clog2(MAX_POINTS + 1);
    localparam int CW = (SW > POINT_COUNT_W) ? SW : POINT_COUNT_W;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_POINTS);

    // Control state.
    state_t                   state_reg, state_next;
    logic [HYST_W-1:0]        hyst_reg;
    logic [POINT_COUNT_W-1:0] count_reg;
    logic [TEMP_W-1:0]        prev_temp_reg, prev_temp_next;
    logic [TEMP_W-1:0]        ref_temp_reg, ref_temp_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     match_reg, match_next;
    logic                     hi_found_reg, hi_found_next;
    logic [CW-1:0]            cur_reg, cur_next;

    // Payload of the sample in flight.
    logic [CW-1:0]            n_reg, n_next;
    logic [TEMP_W-1:0]        t_reg, t_next;
    logic [SPEED_W-1:0]       match_spd_reg, match_spd_next;
    logic [TEMP_W-1:0]        t0_reg, t0_next;
    logic [SPEED_W-1:0]       s0_reg, s0_next;
    logic [TEMP_W-1:0]        last_t_reg, last_t_next;
    logic [SPEED_W-1:0]       last_s_reg, last_s_next;
    logic [TEMP_W-1:0]        lt_reg, lt_next;
    logic [SPEED_W-1:0]       ls_reg, ls_next;
    logic [TEMP_W-1:0]        ht_reg, ht_next;
    logic [SPEED_W-1:0]       hs_reg, hs_next;
    logic                     neg_reg, neg_next;
    logic [SPEED_W-1:0]       res_reg, res_next;
    logic [SPEED_W-1:0]       fan_speed_reg, fan_speed_next;

    // Memory and divider connections.
    logic                     mem_wr_en;
    logic [CW-1:0]            wr_idx;
    curve_entry_t             wr_entry;
    logic                     mem_rd_en;
    logic [CW-1:0]            rd_idx;
    curve_entry_t             rd_entry;
    div_request_t             div_req;
    div_result_t              div_res;

    // Working signals.
    logic                     in_accept;
    logic [CW-1:0]            n_eff;
    logic signed [TEMP_W+1:0] ref_drop;
    logic                     in_band;
    logic                     take_sample;
    logic                     last_slot;
    logic                     match_now;
    logic [SPEED_W-1:0]       match_spd_now;
    logic [TEMP_W-1:0]        t0_now;
    logic [SPEED_W-1:0]       s0_now;
    logic signed [SPEED_W:0]  spd_diff;
    logic [SPEED_W-1:0]       spd_mag;
    logic [TEMP_W-1:0]        temp_off;
    logic [SPEED_W:0]         quot_adj;
    logic [TEMP_W+1:0]        interp;
    logic                     out_free;

    fcwh_curve_mem #(
        .DEPTH (MAX_POINTS),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (wr_idx[AW-1:0]),
        .wr_data (wr_entry),
        .rd_en   (mem_rd_en),
        .rd_addr (rd_idx[AW-1:0]),
        .rd_data (rd_entry)
    );

    fcwh_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .res   (div_res)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign fan_speed = fan_speed_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // Curve point writes go straight to the memory; slots past the table
    // are dropped.
    assign wr_idx         = CW'(point_index);
    assign wr_entry.temp  = temperature;
    assign wr_entry.speed = point_speed;
    assign mem_wr_en      = in_accept && (req_type == REQ_WRITE) && (wr_idx < MAX_CNT);

    always_comb
    begin
        n_eff = (CW'(count_reg) > MAX_CNT) ? MAX_CNT : CW'(count_reg);

        // A falling sample inside the hysteresis band is suppressed.
        ref_drop = $signed({2'b00, ref_temp_reg}) - $signed({2'b00, temperature});
        in_band  = (temperature < prev_temp_reg)
                   && ($signed({2'b00, hyst_reg}) > ref_drop);
        take_sample = (temperature != prev_temp_reg) && !in_band && (n_eff != '0);

        // Slot cur_reg arrives from the memory during the scan.
        last_slot     = (CW'(cur_reg + 1'b1) == n_reg);
        match_now     = match_reg || (rd_entry.temp == t_reg);
        match_spd_now = match_reg ? match_spd_reg : rd_entry.speed;
        t0_now        = (cur_reg == '0) ? rd_entry.temp  : t0_reg;
        s0_now        = (cur_reg == '0) ? rd_entry.speed : s0_reg;

        // Signed speed span and temperature offset for the interpolation.
        spd_diff = $signed({1'b0, hs_reg}) - $signed({1'b0, ls_reg});
        spd_mag  = spd_diff[SPEED_W] ? SPEED_W'(-spd_diff) : spd_diff[SPEED_W-1:0];
        temp_off = t_reg - lt_reg;

        // Floor of a negative quotient rounds one further when inexact.
        quot_adj = div_res.quot[SPEED_W:0]
                   + {{SPEED_W{1'b0}}, (neg_reg && (div_res.rem != '0))};
        interp   = neg_reg ? ({3'b000, ls_reg} - {2'b00, quot_adj})
                           : ({3'b000, ls_reg} + {2'b00, quot_adj});

        state_next     = state_reg;
        prev_temp_next = prev_temp_reg;
        ref_temp_next  = ref_temp_reg;
        out_valid_next = out_valid_reg && out_stall;
        match_next     = match_reg;
        hi_found_next  = hi_found_reg;
        cur_next       = cur_reg;
        n_next         = n_reg;
        t_next         = t_reg;
        match_spd_next = match_spd_reg;
        t0_next        = t0_reg;
        s0_next        = s0_reg;
        last_t_next    = last_t_reg;
        last_s_next    = last_s_reg;
        lt_next        = lt_reg;
        ls_next        = ls_reg;
        ht_next        = ht_reg;
        hs_next        = hs_reg;
        neg_next       = neg_reg;
        res_next       = res_reg;
        fan_speed_next = fan_speed_reg;
        mem_rd_en      = 1'b0;
        rd_idx         = CW'(cur_reg + 1'b1);
        div_req.start  = 1'b0;
        div_req.num    = NUM_W'(spd_mag) * NUM_W'(temp_off);
        div_req.den    = ht_reg - lt_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (req_type == REQ_SAMPLE))
                begin
                    prev_temp_next = temperature;
                    if (take_sample)
                    begin
                        ref_temp_next = temperature;
                        t_next        = temperature;
                        n_next        = n_eff;
                        cur_next      = '0;
                        match_next    = 1'b0;
                        hi_found_next = 1'b0;
                        mem_rd_en     = 1'b1;
                        rd_idx        = '0;
                        state_next    = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (!match_reg && (rd_entry.temp == t_reg))
                begin
                    match_next     = 1'b1;
                    match_spd_next = rd_entry.speed;
                end
                if (cur_reg == '0)
                begin
                    t0_next = rd_entry.temp;
                    s0_next = rd_entry.speed;
                end
                // The upper bound is the first slot after slot zero that lies
                // above the sample; the lower bound is the slot before it.
                if ((cur_reg != '0) && !hi_found_reg && (rd_entry.temp > t_reg))
                begin
                    hi_found_next = 1'b1;
                    ht_next       = rd_entry.temp;
                    hs_next       = rd_entry.speed;
                    lt_next       = last_t_reg;
                    ls_next       = last_s_reg;
                end
                last_t_next = rd_entry.temp;
                last_s_next = rd_entry.speed;

                if (last_slot)
                begin
                    priority if (match_now)
                    begin
                        res_next   = match_spd_now;
                        state_next = ST_FIN;
                    end
                    else if (t_reg <= t0_now)
                    begin
                        res_next   = s0_now;
                        state_next = ST_FIN;
                    end
                    else if (t_reg >= rd_entry.temp)
                    begin
                        res_next   = rd_entry.speed;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_MUL;
                    end
                end
                else
                begin
                    mem_rd_en = 1'b1;
                    cur_next  = CW'(cur_reg + 1'b1);
                end
            end

            ST_MUL:
            begin
                // The product is captured by the divider at this edge.
                neg_next      = spd_diff[SPEED_W];
                div_req.start = 1'b1;
                state_next    = ST_DIV;
            end

            ST_DIV:
            begin
                if (div_res.done)
                begin
                    res_next   = interp[SPEED_W-1:0];
                    state_next = ST_FIN;
                end
            end

            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    fan_speed_next = res_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hyst_reg      <= '0;
            count_reg     <= '0;
            prev_temp_reg <= '0;
            ref_temp_reg  <= '0;
            out_valid_reg <= 1'b0;
            match_reg     <= 1'b0;
            hi_found_reg  <= 1'b0;
            cur_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_temp_reg <= prev_temp_next;
            ref_temp_reg  <= ref_temp_next;
            out_valid_reg <= out_valid_next;
            match_reg     <= match_next;
            hi_found_reg  <= hi_found_next;
            cur_reg       <= cur_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_HYSTERESIS:  hyst_reg  <= cfg_wdata[HYST_W-1:0];
                    REG_POINT_COUNT: count_reg <= cfg_wdata[POINT_COUNT_W-1:0];
                    default:         hyst_reg  <= hyst_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        t_reg         <= t_next;
        match_spd_reg <= match_spd_next;
        t0_reg        <= t0_next;
        s0_reg        <= s0_next;
        last_t_reg    <= last_t_next;
        last_s_reg    <= last_s_next;
        lt_reg        <= lt_next;
        ls_reg        <= ls_next;
        ht_reg        <= ht_next;
        hs_reg        <= hs_next;
        neg_reg       <= neg_next;
        res_reg       <= res_next;
        fan_speed_reg <= fan_speed_next;
    end

endmodule

@@ test/fcwh_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcwh_checker
// Watches the register, request and speed ports of the fan curve block,
// keeps its own copy of the curve and hysteresis state, and compares every
// delivered fan speed with the predicted one.
// ----------------------------------------------------------------------------
module fcwh_checker
    import fcwh_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,

    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic                   req_type,
    input  logic [TEMP_W-1:0]      temperature,
    input  logic [INDEX_W-1:0]     point_index,
    input  logic [SPEED_W-1:0]     point_speed,

    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic [SPEED_W-1:0]     fan_speed,

    output int                     failures,
    output int                     pending
);

    logic [TEMP_W-1:0]        pt_temp  [MAX_POINTS];
    logic [SPEED_W-1:0]       pt_speed [MAX_POINTS];
    logic [TEMP_W-1:0]        last_sample;
    logic [TEMP_W-1:0]        hyst_ref;
    logic [HYST_W-1:0]        hyst_band;
    logic [POINT_COUNT_W-1:0] points_used;
    logic [SPEED_W-1:0]       speed_queue [$];
    logic [SPEED_W-1:0]       want_speed;
    int                       err_count;
    int                       eff_points;

    // Speed for temperature t on a curve of n points. The interpolation
    // rounds toward minus infinity, which equals truncation of the
    // (never negative) exact speed.
    function automatic logic [SPEED_W-1:0] map_speed(input logic [TEMP_W-1:0] t,
                                                     input int n);
        int i;
        int hi;
        int lt;
        int ht;
        int ls;
        int hs;
        int num;
        int den;
        int q;
        for (i = 0; i < n; i++)
            if (pt_temp[i] == t)
                return pt_speed[i];
        if (t <= pt_temp[0])
            return pt_speed[0];
        if (t >= pt_temp[n-1])
            return pt_speed[n-1];
        hi = n - 1;
        for (i = 1; i < n; i++)
        begin
            if (pt_temp[i] > t)
            begin
                hi = i;
                break;
            end
        end
        lt = int'(pt_temp[hi-1]);
        ht = int'(pt_temp[hi]);
        ls = int'(pt_speed[hi-1]);
        hs = int'(pt_speed[hi]);
        if (ht <= lt)
            return pt_speed[hi-1];
        num = (hs - ls) * (int'(t) - lt);
        den = ht - lt;
        q = num / den;
        if ((num % den) != 0 && num < 0)
            q = q - 1;
        q = ls + q;
        if (q < 0)
            q = 0;
        return q[SPEED_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_sample = '0;
            hyst_ref    = '0;
            hyst_band   = '0;
            points_used = '0;
            err_count   = 0;
            speed_queue.delete();
            failures   <= 0;
            pending    <= 0;
        end
        else
        begin
            // Speeds leaving the block belong to earlier requests, so they
            // are matched before this edge's request is predicted.
            if (out_valid && !out_stall)
            begin
                if (speed_queue.size() == 0)
                begin
                    $error("fan_speed: expected nothing, actual %0d", fan_speed);
                    err_count++;
                end
                else
                begin
                    want_speed = speed_queue.pop_front();
                    if (fan_speed !== want_speed)
                    begin
                        $error("fan_speed: expected %0d, actual %0d", want_speed, fan_speed);
                        err_count++;
                    end
                end
            end

            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_HYSTERESIS:  hyst_band   = cfg_wdata[HYST_W-1:0];
                    REG_POINT_COUNT: points_used = cfg_wdata[POINT_COUNT_W-1:0];
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
            begin
                if (req_type == REQ_WRITE)
                begin
                    if (point_index < MAX_POINTS)
                    begin
                        pt_temp[point_index]  = temperature;
                        pt_speed[point_index] = point_speed;
                    end
                end
                else
                begin
                    eff_points = (points_used > MAX_POINTS) ? MAX_POINTS : int'(points_used);
                    if (temperature != last_sample
                        && !(temperature < last_sample
                             && int'(hyst_band) > int'(hyst_ref) - int'(temperature))
                        && eff_points != 0)
                    begin
                        hyst_ref = temperature;
                        speed_queue.push_back(map_speed(temperature, eff_points));
                    end
                    last_sample = temperature;
                end
            end

            failures <= err_count;
            pending  <= speed_queue.size();
        end
    end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the fan curve block with curve point writes and temperature samples
// under random idling on both channels, and reports the verdict of the
// checker that watches the ports.
// ----------------------------------------------------------------------------
module tb_top
    import fcwh_pkg::*;
();

    // Cycles allowed after the last expected speed before the block is taken
    // as idle, long enough to cover the slowest request (an interpolation over
    // 16 points) still in flight.
    localparam int SETTLE_CYCLES  = 40;
    // Number of requests in the random part.
    localparam int RANDOM_ITEMS   = 1300;
    // Longest run of cycles with no accepted request, speed or register
    // write. The worst correct run is a long sender gap or a long result stall
    // plus a slow request.
    localparam int WATCHDOG_LIMIT = 3000;

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata   = '0;
    logic                   in_valid    = 1'b0;
    logic                   in_stall;
    logic                   req_type    = REQ_SAMPLE;
    logic [TEMP_W-1:0]      temperature = '0;
    logic [INDEX_W-1:0]     point_index = '0;
    logic [SPEED_W-1:0]     point_speed = '0;
    logic                   out_valid;
    logic                   out_stall   = 1'b0;
    logic [SPEED_W-1:0]     fan_speed;

    int failures;
    int pending;

    // Stimulus bookkeeping.
    int items_sent = 0;
    bit no_gaps    = 1'b0;
    int last_t     = 0;

    // Result side idling.
    int stall_hold;
    int stall_pick;

    // Watchdog.
    int idle_cycles = 0;

    always #6 clk = ~clk;

    fan_curve_with_hysteresis DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .temperature (temperature),
        .point_index (point_index),
        .point_speed (point_speed),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .fan_speed   (fan_speed)
    );

    fcwh_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .temperature (temperature),
        .point_index (point_index),
        .point_speed (point_speed),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .fan_speed   (fan_speed),
        .failures    (failures),
        .pending     (pending)
    );

    // The result side alternates between stretches of stalling and
    // stretches of taking every speed. Most stretches are short, a few stall
    // for a long time, and some long ones never stall at all. A new choice
    // is made only when the previous stretch has run out, so out_stall gets
    // a single assignment per edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_hold <= 0;
        end
        else if (stall_hold != 0)
        begin
            stall_hold <= stall_hold - 1;
        end
        else
        begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 50)
            begin
                out_stall  <= 1'b0;
                stall_hold <= $urandom_range(0, 4);
            end
            else if (stall_pick < 82)
            begin
                out_stall  <= 1'b1;
                stall_hold <= $urandom_range(0, 4);
            end
            else if (stall_pick < 90)
            begin
                out_stall  <= 1'b1;
                stall_hold <= $urandom_range(20, 100);
            end
            else
            begin
                out_stall  <= 1'b0;
                stall_hold <= $urandom_range(50, 300);
            end
        end
    end

    // The watchdog restarts whenever anything moves on any port. If nothing
    // moves for too long the block is hung and the run ends.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Offers one request and returns at the edge where it is accepted. A
    // random gap may come first; during a gap valid is low. The task returns
    // without touching valid, so the next request or gap makes the only
    // assignment to it in that step.
    task automatic send_req(input logic kind, input logic [TEMP_W-1:0] t,
                            input logic [INDEX_W-1:0] idx,
                            input logic [SPEED_W-1:0] spd);
        int gap;
        int r;
        gap = 0;
        if (!no_gaps)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                gap = 0;
            else if (r < 90)
                gap = $urandom_range(1, 3);
            else if (r < 97)
                gap = $urandom_range(4, 10);
            else
                gap = $urandom_range(20, 60);
        end
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= kind;
        temperature <= t;
        point_index <= idx;
        point_speed <= spd;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    // Stops sending and waits until every predicted speed has been taken,
    // then lets the given number of cycles pass. The first edge is waited
    // for before the pending count is looked at, since a request accepted at
    // the current edge only shows up in the count after it.
    task automatic drain_all(input int settle);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Writes the hysteresis register and then the point count register. Called only while the
    // block is idle.
    task automatic set_regs(input int hyst, input int count);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_HYSTERESIS;
        cfg_wdata <= hyst[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_index <= REG_POINT_COUNT;
        cfg_wdata <= count[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Loads slots 0 to n-1. A sorted curve spreads its temperatures over
    // the whole range in rising order. An unsorted one draws from a coarse
    // grid so that repeated temperatures turn up often. Now and then a
    // speed above 100 is written.
    task automatic write_curve(input int n, input bit sorted);
        int spacing;
        int i;
        int t;
        int s;
        if (n == 0)
            return;
        spacing = 256 / n;
        for (i = 0; i < n; i++)
        begin
            if (sorted)
                t = i * spacing + $urandom_range(0, spacing - 1);
            else
                t = $urandom_range(0, 31) * 8 + $urandom_range(0, 1) * 7;
            if ($urandom_range(0, 9) == 0)
                s = $urandom_range(101, 127);
            else
                s = $urandom_range(0, 100);
            send_req(REQ_WRITE, t[TEMP_W-1:0], i[INDEX_W-1:0], s[SPEED_W-1:0]);
        end
    endtask

    initial
    begin
        int h;
        int c;
        int n_eff;
        int m;
        int k;
        int r;
        int tv;
        bit drain_mid;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. With no points in use a sample gives no speed,
        // whether it repeats the previous sample or not.
        send_req(REQ_SAMPLE, 8'd0, 4'd15, 7'd127);
        send_req(REQ_SAMPLE, 8'd50, 4'd0, 7'd0);

        // A five point curve with a rising run, a speed above 100 and a
        // falling last segment, which makes the interpolation step negative.
        send_req(REQ_WRITE, 8'd20, 4'd0, 7'd0);
        send_req(REQ_WRITE, 8'd40, 4'd1, 7'd30);
        send_req(REQ_WRITE, 8'd60, 4'd2, 7'd100);
        send_req(REQ_WRITE, 8'd80, 4'd3, 7'd127);
        send_req(REQ_WRITE, 8'd200, 4'd4, 7'd10);
        drain_all(SETTLE_CYCLES);
        set_regs(0, 5);

        // Below the first point, above the last, an exact hit, a rising and
        // a falling interpolation, then a repeated sample that gives nothing.
        send_req(REQ_SAMPLE, 8'd0, 4'd7, 7'd99);
        send_req(REQ_SAMPLE, 8'd255, 4'd8, 7'd1);
        send_req(REQ_SAMPLE, 8'd40, 4'd3, 7'd64);
        send_req(REQ_SAMPLE, 8'd50, 4'd12, 7'd5);
        send_req(REQ_SAMPLE, 8'd150, 4'd1, 7'd77);
        send_req(REQ_SAMPLE, 8'd150, 4'd2, 7'd33);

        // With a band of ten degrees a drop of five is held, a drop of
        // exactly ten below the reference gives a new speed again.
        drain_all(SETTLE_CYCLES);
        set_regs(10, 5);
        send_req(REQ_SAMPLE, 8'd145, 4'd9, 7'd11);
        send_req(REQ_SAMPLE, 8'd140, 4'd4, 7'd22);
        send_req(REQ_SAMPLE, 8'd10, 4'd5, 7'd44);
        send_req(REQ_SAMPLE, 8'd200, 4'd6, 7'd88);
        last_t = 200;

        // Random part. All sixteen slots are filled first, so no sample
        // can ever look at a slot that was never written.
        write_curve(16, 1'b1);
        items_sent = 0;

        while (items_sent < RANDOM_ITEMS)
        begin
            // Each phase starts from a new register setting, taken with
            // weight on the extremes: no band, the widest band, no points,
            // one point, a full curve and counts past the end of the table.
            r = $urandom_range(0, 99);
            if (r < 25)
                h = 0;
            else if (r < 35)
                h = 255;
            else if (r < 85)
                h = $urandom_range(1, 40);
            else
                h = $urandom_range(0, 255);
            r = $urandom_range(0, 99);
            if (r < 8)
                c = 0;
            else if (r < 18)
                c = 1;
            else if (r < 28)
                c = 2;
            else if (r < 48)
                c = 16;
            else if (r < 58)
                c = $urandom_range(17, 31);
            else
                c = $urandom_range(3, 15);

            drain_all(SETTLE_CYCLES);
            set_regs(h, c);
            n_eff = (c > 16) ? 16 : c;

            // Some phases run with the sender never idling.
            no_gaps = ($urandom_range(0, 4) == 0);
            write_curve(n_eff, $urandom_range(0, 4) != 0);

            // Samples mostly walk up and down around the previous one, so
            // the hysteresis band decides often. Repeats, jumps anywhere and
            // stray point writes are mixed in.
            m = $urandom_range(20, 60);
            drain_mid = ($urandom_range(0, 2) == 0);
            for (k = 0; k < m; k++)
            begin
                if (drain_mid && k == m / 2)
                    drain_all(0);
                r = $urandom_range(0, 99);
                if (r < 5)
                begin
                    send_req(REQ_WRITE, TEMP_W'($urandom_range(0, 255)),
                             INDEX_W'($urandom_range(0, 15)),
                             SPEED_W'($urandom_range(0, 127)));
                end
                else
                begin
                    if (r < 14)
                        tv = last_t;
                    else if (r < 28)
                        tv = $urandom_range(0, 255);
                    else if (r < 62)
                        tv = last_t + $urandom_range(1, 24);
                    else
                        tv = last_t - $urandom_range(0, h + 12);
                    if (tv < 0)
                        tv = 0;
                    if (tv > 255)
                        tv = 255;
                    send_req(REQ_SAMPLE, tv[TEMP_W-1:0], INDEX_W'($urandom),
                             SPEED_W'($urandom));
                    last_t = tv;
                end
            end
        end

        // Everything has been sent: wait for the last speeds, give the block
        // time to finish a sample that produces none, then report.
        no_gaps = 1'b0;
        drain_all(SETTLE_CYCLES);
        if (failures == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ fan_curve_with_hysteresis.f @@
hw/rtl/fcwh_pkg.sv
hw/rtl/fcwh_curve_mem.sv
hw/rtl/fcwh_div.sv
hw/rtl/fan_curve_with_hysteresis.sv
test/fcwh_checker.sv
test/tb_top.sv
